/* design/rpcd_pkg.sv */
// Shared types, constants and register codes for the RC pulse capture decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rpcd_pkg;

   // Channel store depth default and field widths
   localparam int NUM_CHANNELS_DEF = 8;
   localparam int STAMP_W          = 16;
   localparam int CHAN_W           = 3;
   localparam int CSR_INDEX_W      = 3;
   localparam int REQ_DATA_W       = 24;
   localparam int RSP_DATA_W       = 24;

   // Good-frame tracking covers the first four channels
   localparam int          GOOD_CHANNELS = 4;
   localparam logic [3:0]  GOOD_ALL      = 4'hF;

   // Configuration reset values
   localparam logic              MODE_RESET      = 1'b1;
   localparam logic [STAMP_W-1:0] SYNC_GAP_RESET  = 16'd2700;
   localparam logic [STAMP_W-1:0] WIDTH_MIN_RESET = 16'd750;
   localparam logic [STAMP_W-1:0] WIDTH_MAX_RESET = 16'd2250;
   localparam logic [STAMP_W-1:0] GOOD_THR_RESET  = 16'd985;

   // Decode modes
   localparam logic MODE_PWM = 1'b0;
   localparam logic MODE_PPM = 1'b1;

   // Input actions
   localparam logic ACTION_EDGE = 1'b0;
   localparam logic ACTION_READ = 1'b1;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DECODE_MODE    = 3'd0,
      CSR_SYNC_GAP       = 3'd1,
      CSR_WIDTH_MIN      = 3'd2,
      CSR_WIDTH_MAX      = 3'd3,
      CSR_GOOD_THRESHOLD = 3'd4
   } rpcd_csr_type;

   // Operation picked by the front for the back to carry out
   typedef enum logic [1:0] {
      OP_READ = 2'd0,
      OP_PPM  = 2'd1,
      OP_PWM  = 2'd2,
      OP_SKIP = 2'd3
   } rpcd_op_type;

   // Configuration register set
   typedef struct packed {
      logic               mode;
      logic [STAMP_W-1:0] sync_gap;
      logic [STAMP_W-1:0] width_min;
      logic [STAMP_W-1:0] width_max;
      logic [STAMP_W-1:0] good_threshold;
   } rpcd_cfg_type;

   // Classified word held in the queue
   typedef struct packed {
      rpcd_op_type        op;
      logic               in_range;
      logic [STAMP_W-1:0] stamp;
      logic [CHAN_W-1:0]  channel;
   } rpcd_item_type;

   // Result word
   typedef struct packed {
      logic               width_valid;
      logic [CHAN_W-1:0]  out_channel;
      logic [STAMP_W-1:0] width;
      logic               frame_sync;
      logic               good_frame;
      logic               failsafe_clear;
   } rpcd_rsp_type;

   // Queue depth between front and back
   localparam int QUEUE_DEPTH = 2;

endpackage

/* design/rpcd_front.sv */
// Front end: unpacks request words and classifies them into decoder operations.
// Depends on rpcd_pkg; feeds rpcd_queue.
module rpcd_front #(
   parameter int NUM_CHANNELS = rpcd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: timestamp[15:0], channel[18:16], zero pad
   input  logic [rpcd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: action
   input  logic                                req_tuser,
   input  rpcd_pkg::rpcd_cfg_type              cfg,
   input  logic                                queue_full,
   output logic                                push,
   output rpcd_pkg::rpcd_item_type             item
);
   import rpcd_pkg::*;

   logic [CHAN_W-1:0] channel;
   logic              in_range;

   // Accept while the queue has room
   assign req_tready = !queue_full;
   assign push       = req_tvalid && !queue_full;

   assign channel  = req_tdata[STAMP_W +: CHAN_W];
   assign in_range = (32'(channel) < NUM_CHANNELS);

   // Classify by action, mode and channel range
   always_comb begin
      item.stamp    = req_tdata[STAMP_W-1:0];
      item.channel  = channel;
      item.in_range = in_range;
      if (req_tuser == ACTION_READ) begin
         item.op = OP_READ;
      end else if (cfg.mode == MODE_PPM) begin
         item.op = OP_PPM;
      end else if (in_range) begin
         item.op = OP_PWM;
      end else begin
         item.op = OP_SKIP;
      end
   end

endmodule

/* design/rpcd_queue.sv */
// Two-word queue between the front end and the execution back end.
// Depends on rpcd_pkg for the item type and depth.
module rpcd_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rpcd_pkg::rpcd_item_type push_item,
   input  logic                    pop,
   output logic                    head_valid,
   output rpcd_pkg::rpcd_item_type head_item,
   output logic                    full
);
   import rpcd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   rpcd_item_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign full       = (32'(count_ff) == QUEUE_DEPTH);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold payload words
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* design/rpcd_back.sv */
// Back end: configuration registers, decoder state and the registered result word.
// Depends on rpcd_pkg; takes words from rpcd_queue.
module rpcd_back #(
   parameter int NUM_CHANNELS = rpcd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [rpcd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rpcd_pkg::STAMP_W-1:0]         csr_data,
   output rpcd_pkg::rpcd_cfg_type               cfg,
   input  logic                                 head_valid,
   input  rpcd_pkg::rpcd_item_type              head_item,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output rpcd_pkg::rpcd_rsp_type               rsp
);
   import rpcd_pkg::*;

   localparam int IDX_W = $clog2(NUM_CHANNELS);
   localparam int FC_W  = $clog2(NUM_CHANNELS + 1);

   rpcd_cfg_type        cfg_ff;
   logic [STAMP_W-1:0]  store_ff [NUM_CHANNELS];
   logic [STAMP_W-1:0]  store_in [NUM_CHANNELS];
   logic [STAMP_W-1:0]  rise_ff  [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] phase_ff, phase_in;
   logic [STAMP_W-1:0]  last_ff, last_in;
   logic [FC_W-1:0]     fc_ff, fc_in;
   logic [3:0]          mask_ff, mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rpcd_rsp_type        rsp_ff, rsp_in;

   logic [IDX_W-1:0]    cidx;
   logic [IDX_W-1:0]    fidx;
   logic                fc_lt_n;
   logic [STAMP_W-1:0]  ppm_diff;
   logic [STAMP_W-1:0]  pwm_diff;
   logic [3:0]          mask_set;
   logic                rise_we;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Take a word when the result register is free or drains this cycle
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);

   assign cidx     = IDX_W'(head_item.channel);
   assign fidx     = IDX_W'(fc_ff);
   assign fc_lt_n  = (32'(fc_ff) < NUM_CHANNELS);
   assign ppm_diff = head_item.stamp - last_ff;
   assign pwm_diff = head_item.stamp - rise_ff[cidx];
   assign mask_set = mask_ff | (4'b0001 << fc_ff[1:0]);

   // Execute the head word
   always_comb begin
      store_in     = store_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      fc_in        = fc_ff;
      mask_in      = mask_ff;
      rise_we      = 1'b0;
      rsp_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pop) begin
         rsp_valid_in = 1'b1;
         case (head_item.op)
            OP_READ: begin
               rsp_in.out_channel = head_item.channel;
               rsp_in.width       = head_item.in_range ? store_ff[cidx] : '0;
            end
            OP_PPM: begin
               last_in = head_item.stamp;
               if (ppm_diff > cfg_ff.sync_gap) begin
                  fc_in             = '0;
                  rsp_in.frame_sync = 1'b1;
               end else begin
                  if (ppm_diff > cfg_ff.width_min && ppm_diff < cfg_ff.width_max
                      && fc_lt_n) begin
                     store_in[fidx]     = ppm_diff;
                     rsp_in.width_valid = 1'b1;
                     rsp_in.out_channel = CHAN_W'(fc_ff);
                     rsp_in.width       = ppm_diff;
                     if (32'(fc_ff) < GOOD_CHANNELS && ppm_diff > cfg_ff.good_threshold)
                     begin
                        mask_in = mask_set;
                     end
                     if (mask_in == GOOD_ALL) begin
                        mask_in           = '0;
                        rsp_in.good_frame = 1'b1;
                     end
                  end
                  if (fc_lt_n) begin
                     fc_in = fc_ff + 1'b1;
                  end
                  rsp_in.failsafe_clear = 1'b1;
               end
            end
            OP_PWM: begin
               if (!phase_ff[cidx]) begin
                  rise_we        = 1'b1;
                  phase_in[cidx] = 1'b1;
               end else begin
                  store_in[cidx]        = pwm_diff;
                  phase_in[cidx]        = 1'b0;
                  rsp_in.width_valid    = 1'b1;
                  rsp_in.out_channel    = head_item.channel;
                  rsp_in.width          = pwm_diff;
                  rsp_in.failsafe_clear = 1'b1;
               end
            end
            default: begin
               rsp_in = '0;
            end
         endcase
      end
   end

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode           <= MODE_RESET;
         cfg_ff.sync_gap       <= SYNC_GAP_RESET;
         cfg_ff.width_min      <= WIDTH_MIN_RESET;
         cfg_ff.width_max      <= WIDTH_MAX_RESET;
         cfg_ff.good_threshold <= GOOD_THR_RESET;
      end else if (csr_valid) begin
         case (rpcd_csr_type'(csr_index))
            CSR_DECODE_MODE:    cfg_ff.mode           <= csr_data[0];
            CSR_SYNC_GAP:       cfg_ff.sync_gap       <= csr_data;
            CSR_WIDTH_MIN:      cfg_ff.width_min      <= csr_data;
            CSR_WIDTH_MAX:      cfg_ff.width_max      <= csr_data;
            CSR_GOOD_THRESHOLD: cfg_ff.good_threshold <= csr_data;
            default:            cfg_ff                <= cfg_ff;
         endcase
      end
   end

   // Update decoder state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            store_ff[i] <= '0;
         end
         phase_ff     <= '0;
         last_ff      <= '0;
         fc_ff        <= '0;
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         store_ff     <= store_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         fc_ff        <= fc_in;
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold rising-edge stamps and the result payload
   always_ff @(posedge clock) begin
      if (rise_we) begin
         rise_ff[cidx] <= head_item.stamp;
      end
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

/* design/rc_pulse_capture_decoder_unit.sv */
// Top level of the RC pulse capture decoder: front end, queue and back end.
// Depends on rpcd_pkg, rpcd_front, rpcd_queue and rpcd_back.
//
// Decodes RC receiver input from 16-bit capture timestamps, as a PPM pulse train
// (decode_mode 1) or as per-channel PWM edge pairs (decode_mode 0), and answers
// read requests for stored channel widths. Every request word yields exactly one
// response word. The block accepts one word per clock cycle sustained while
// rsp_tready stays high; a request lands in the front-to-back queue when it is
// accepted and then moves into the registered response stage, where its
// response is presented. While a response waits for rsp_tready the two-word queue
// takes up to two more requests before req_tready drops. The per-word work is
// one 16-bit subtract with its compares and a store update in the back end.
// Configuration writes are to be issued only while no request is in flight.
module rc_pulse_capture_decoder_unit #(
   parameter int NUM_CHANNELS = rpcd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: timestamp[15:0], channel[18:16], zero pad [23:19]
   input  logic [rpcd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: action
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: out_channel[2:0], width[18:3], frame_sync[19], good_frame[20],
   //        failsafe_clear[21], zero pad [23:22]
   output logic [rpcd_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: width_valid
   output logic                                rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rpcd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rpcd_pkg::STAMP_W-1:0]        csr_data
);
   import rpcd_pkg::*;

   rpcd_cfg_type  cfg;
   rpcd_item_type push_item;
   rpcd_item_type head_item;
   rpcd_rsp_type  rsp;
   logic          push;
   logic          pop;
   logic          head_valid;
   logic          queue_full;

   rpcd_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   rpcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (queue_full)
   );

   rpcd_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cfg        (cfg),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   // Pack the response word
   assign rsp_tuser = rsp.width_valid;
   assign rsp_tdata = {2'b00, rsp.failsafe_clear, rsp.good_frame, rsp.frame_sync,
                       rsp.width, rsp.out_channel};

   // A good frame is only reported with a stored width on one of channels 0 to 3
   a_good_frame_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[20] |-> rsp_tuser && !rsp_tdata[2])
      else $error("good_frame without a stored width on channels 0 to 3");

   // A sync gap never stores a width or clears failsafe
   a_sync_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[19] |-> !rsp_tuser && !rsp_tdata[21] && !rsp_tdata[20])
      else $error("frame_sync combined with a width or failsafe clear");

   // A stored width always clears the failsafe counter
   a_store_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[21])
      else $error("stored width without failsafe_clear");

endmodule
